// File: hdl/fpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpm_pkg;

   localparam int unsigned ModBits = 30;

   localparam logic [ModBits-1:0] FibMod = 30'd1000000007;

   // floor(2^60 / p)
   localparam logic [30:0] BarrettMu =
      31'(64'd1152921504606846976 / 64'd1000000007);

   typedef struct packed {
      logic               start;
      logic [ModBits-1:0] op_a;
      logic [ModBits-1:0] op_b;
   } mm_req_type;

   typedef struct packed {
      logic               done;
      logic [ModBits-1:0] result;
   } mm_rsp_type;

endpackage

`default_nettype wire

// File: hdl/fpm_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module fpm_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

`default_nettype wire

// File: hdl/fpm_modmul.sv
`timescale 1ns / 1ps
`default_nettype none

module fpm_modmul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fpm_pkg::mm_req_type mm_req,
   output fpm_pkg::mm_rsp_type      mm_rsp
);

   import fpm_pkg::*;

   typedef enum logic [1:0] {
      MM_IDLE,
      MM_Q2,
      MM_Q3,
      MM_RED
   } mm_state_type;

   localparam logic [31:0] ModWide = {2'b00, FibMod};
   localparam logic [31:0] ModTwice = {1'b0, FibMod, 1'b0};

   mm_state_type       state_ff;
   logic               done_ff;
   logic [ModBits-1:0] result_ff;
   logic [31:0]        plo_ff;
   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        prod_ff;
   logic [31:0]        rem_raw;
   logic [31:0]        rem_in;

   fpm_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Barrett: q1 = P >> 29, q3 = (q1 * mu) >> 31, r = P - q3 * p, r < 3p
   always_comb begin
      case (state_ff)
         MM_IDLE: begin
            mul_a = {2'b00, mm_req.op_a};
            mul_b = {2'b00, mm_req.op_b};
         end
         MM_Q2: begin
            mul_a = {1'b0, prod_ff[59:29]};
            mul_b = {1'b0, BarrettMu};
         end
         MM_Q3: begin
            mul_a = {1'b0, prod_ff[61:31]};
            mul_b = ModWide;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rem_raw = plo_ff - prod_ff[31:0];
      if (rem_raw >= ModTwice) begin
         rem_in = rem_raw - ModTwice;
      end else if (rem_raw >= ModWide) begin
         rem_in = rem_raw - ModWide;
      end else begin
         rem_in = rem_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == MM_RED);
         case (state_ff)
            MM_IDLE: begin
               if (mm_req.start) begin
                  state_ff <= MM_Q2;
               end
            end
            MM_Q2: begin
               plo_ff   <= prod_ff[31:0];
               state_ff <= MM_Q3;
            end
            MM_Q3: begin
               state_ff <= MM_RED;
            end
            MM_RED: begin
               result_ff <= rem_in[ModBits-1:0];
               state_ff  <= MM_IDLE;
            end
            default: begin
               state_ff <= MM_IDLE;
            end
         endcase
      end
   end

   assign mm_rsp.done   = done_ff;
   assign mm_rsp.result = result_ff;

   assert property (@(posedge clock) disable iff (reset)
      mm_req.start |-> state_ff == MM_IDLE)
      else $error("modmul started while busy");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> result_ff < FibMod)
      else $error("modmul result not reduced");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == MM_IDLE && mm_req.start) |=> ##2 (state_ff == MM_RED))
      else $error("modmul sequence broken");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == MM_IDLE)
      else $error("modmul done while busy");

endmodule

`default_nettype wire

// File: hdl/fibonacci_pair_mod_prime.sv
`timescale 1ns / 1ps
`default_nettype none

// Fibonacci pair modulo 1000000007.
// req channel: req_valid / req_stall with req_index, a signed index n.
// rsp channel: rsp_valid / rsp_stall with F(n) and F(n+1) mod p.
// One item is worked at a time: req_stall is high from acceptance until
// the sequencer is back in idle. The magnitude |n| is walked by fast
// doubling, one round per index bit, MSB first. Each round runs three
// modular multiplies on one shared Barrett unit (one 32x32 multiplier
// reused three times per multiply) plus one issue state. The result
// sits in an output register; while rsp_stall holds it, a new item may
// be accepted, and its result waits in the final state until the
// register frees up.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.

module fibonacci_pair_mod_prime #(
   parameter int INDEX_BITS = 48
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [INDEX_BITS-1:0] req_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [29:0]           rsp_fib_at_index,
   output logic             [29:0]           rsp_fib_at_next
);

   import fpm_pkg::*;

   localparam int CntBits = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULC,
      ST_WAITC,
      ST_WAITAA,
      ST_WAITBB,
      ST_FINISH
   } state_type;

   localparam logic [31:0] ModWide = {2'b00, FibMod};
   localparam logic [31:0] ModTwice = {1'b0, FibMod, 1'b0};

   function automatic logic [ModBits-1:0] add_mod(input logic [ModBits-1:0] x,
                                                  input logic [ModBits-1:0] y);
      logic [ModBits:0] s;
      begin
         s = {1'b0, x} + {1'b0, y};
         if (s >= {1'b0, FibMod}) begin
            s = s - {1'b0, FibMod};
         end
         return s[ModBits-1:0];
      end
   endfunction

   function automatic logic [ModBits-1:0] sub_mod(input logic [ModBits-1:0] x,
                                                  input logic [ModBits-1:0] y);
      logic [ModBits:0] s;
      begin
         if (x >= y) begin
            s = {1'b0, x} - {1'b0, y};
         end else begin
            s = {1'b0, x} + {1'b0, FibMod} - {1'b0, y};
         end
         return s[ModBits-1:0];
      end
   endfunction

   state_type            state_ff;
   logic [CntBits-1:0]   bit_cnt_ff;
   logic [INDEX_BITS-1:0] mag_ff;
   logic                 neg_ff;
   logic [ModBits-1:0]   a_ff;
   logic [ModBits-1:0]   b_ff;
   logic [ModBits-1:0]   c_ff;
   logic [ModBits-1:0]   aa_ff;
   logic                 rsp_valid_ff;
   logic [ModBits-1:0]   f0_ff;
   logic [ModBits-1:0]   f1_ff;

   logic [INDEX_BITS-1:0] raw_in;
   logic [INDEX_BITS-1:0] mag_in;
   logic [31:0]           twob_raw;
   logic [31:0]           twob_red;
   logic [ModBits-1:0]    d_in;
   logic [ModBits-1:0]    f0_in;
   logic [ModBits-1:0]    f1_in;
   logic                  in_take;
   logic                  out_free;

   mm_req_type mm_req;
   mm_rsp_type mm_rsp;

   fpm_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign in_take   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // most negative index wraps to itself: magnitude 2^(INDEX_BITS-1)
   always_comb begin
      raw_in = req_index;
      mag_in = raw_in[INDEX_BITS-1] ? (~raw_in + 1'b1) : raw_in;
   end

   // 2*b - a mod p
   always_comb begin
      twob_raw = {1'b0, b_ff, 1'b0} + ModWide - {2'b00, a_ff};
      if (twob_raw >= ModTwice) begin
         twob_red = twob_raw - ModTwice;
      end else if (twob_raw >= ModWide) begin
         twob_red = twob_raw - ModWide;
      end else begin
         twob_red = twob_raw;
      end
   end

   always_comb begin
      mm_req.start = 1'b0;
      mm_req.op_a  = a_ff;
      mm_req.op_b  = twob_red[ModBits-1:0];
      case (state_ff)
         ST_MULC: begin
            mm_req.start = 1'b1;
         end
         ST_WAITC: begin
            mm_req.start = mm_rsp.done;
            mm_req.op_b  = a_ff;
         end
         ST_WAITAA: begin
            mm_req.start = mm_rsp.done;
            mm_req.op_a  = b_ff;
            mm_req.op_b  = b_ff;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   assign d_in = add_mod(aa_ff, mm_rsp.result);

   always_comb begin
      if (!neg_ff) begin
         f0_in = a_ff;
         f1_in = b_ff;
      end else if (mag_ff[0]) begin
         f0_in = a_ff;
         f1_in = sub_mod(a_ff, b_ff);
      end else begin
         f0_in = sub_mod('0, a_ff);
         f1_in = sub_mod(b_ff, a_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_take) begin
                  mag_ff     <= mag_in;
                  neg_ff     <= raw_in[INDEX_BITS-1];
                  a_ff       <= '0;
                  b_ff       <= ModBits'(1);
                  bit_cnt_ff <= CntBits'(INDEX_BITS - 1);
                  state_ff   <= ST_MULC;
               end
            end
            ST_MULC: begin
               state_ff <= ST_WAITC;
            end
            ST_WAITC: begin
               if (mm_rsp.done) begin
                  c_ff     <= mm_rsp.result;
                  state_ff <= ST_WAITAA;
               end
            end
            ST_WAITAA: begin
               if (mm_rsp.done) begin
                  aa_ff    <= mm_rsp.result;
                  state_ff <= ST_WAITBB;
               end
            end
            ST_WAITBB: begin
               if (mm_rsp.done) begin
                  if (mag_ff[bit_cnt_ff]) begin
                     a_ff <= d_in;
                     b_ff <= add_mod(c_ff, d_in);
                  end else begin
                     a_ff <= c_ff;
                     b_ff <= d_in;
                  end
                  if (bit_cnt_ff == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     bit_cnt_ff <= bit_cnt_ff - 1'b1;
                     state_ff   <= ST_MULC;
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  f0_ff        <= f0_in;
                  f1_ff        <= f1_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fib_at_index = f0_ff;
   assign rsp_fib_at_next  = f1_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (f0_ff < FibMod && f1_ff < FibMod))
      else $error("result not reduced");

   assert property (@(posedge clock) disable iff (reset)
      in_take |=> state_ff == ST_MULC)
      else $error("accepted item did not start a round");

   assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |->
         (state_ff == ST_WAITC || state_ff == ST_WAITAA || state_ff == ST_WAITBB))
      else $error("multiply result arrived outside a wait state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished item not presented");

endmodule

`default_nettype wire

// File: test/tb_fibonacci_pair_mod_prime.sv
`timescale 1ns / 1ps

module tb_fibonacci_pair_mod_prime;

   localparam int IDX_W = 48;
   localparam longint unsigned PRIME = 64'd1000000007;
   localparam int HOLD_AFTER = 40;
   localparam int HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 700;
   localparam int RANDOM_ITEMS = 1125;

   class fib_scoreboard;
      typedef struct {
         logic signed [IDX_W-1:0] index;
         logic [29:0]             f_n;
         logic [29:0]             f_next;
      } fib_pair_type;

      fib_pair_type expected_pairs[$];
      int        mismatches = 0;
      int        accepted = 0;

      function longint unsigned mul_mod(longint unsigned x, longint unsigned y);
         return (x * y) % PRIME;
      endfunction

      // fast doubling over |n|, MSB first, then the negafibonacci fix-up
      function void note_index(logic signed [IDX_W-1:0] idx);
         logic            neg;
         logic [IDX_W-1:0] mag;
         longint unsigned a, b, c, d, twob, f0, f1;
         fib_pair_type    pair;
         neg = idx[IDX_W-1];
         mag = neg ? (~idx + 1'b1) : idx;
         a = 0;
         b = 1;
         for (int k = IDX_W - 1; k >= 0; k--) begin
            twob = (2 * b + PRIME - a) % PRIME;
            c = mul_mod(a, twob);
            d = (mul_mod(a, a) + mul_mod(b, b)) % PRIME;
            if (mag[k]) begin
               a = d;
               b = (c + d) % PRIME;
            end else begin
               a = c;
               b = d;
            end
         end
         if (!neg) begin
            f0 = a;
            f1 = b;
         end else if (mag[0]) begin
            f0 = a;
            f1 = (a + PRIME - b) % PRIME;
         end else begin
            f0 = (PRIME - a) % PRIME;
            f1 = (b + PRIME - a) % PRIME;
         end
         pair.index = idx;
         pair.f_n = f0[29:0];
         pair.f_next = f1[29:0];
         expected_pairs.insert(expected_pairs.size(), pair);
         accepted++;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_pair(logic [29:0] got_n, logic [29:0] got_next);
         fib_pair_type want;
         if (expected_pairs.size() == 0) begin
            report($sformatf("unexpected item F=%0d Fnext=%0d", got_n, got_next));
         end else begin
            want = expected_pairs.pop_front();
            if (got_n !== want.f_n)
               report($sformatf("fib_at_index for n=%0d: got %0d expected %0d",
                                want.index, got_n, want.f_n));
            if (got_next !== want.f_next)
               report($sformatf("fib_at_next for n=%0d: got %0d expected %0d",
                                want.index, got_next, want.f_next));
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [IDX_W-1:0] req_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [29:0]             rsp_fib_at_index;
   logic [29:0]             rsp_fib_at_next;

   fib_scoreboard sb = new();
   bit            calm = 1'b0;

   fibonacci_pair_mod_prime #(
      .INDEX_BITS(IDX_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fib_at_index(rsp_fib_at_index),
      .rsp_fib_at_next (rsp_fib_at_next)
   );

   always #5 clock = ~clock;

   function automatic logic signed [IDX_W-1:0] random_index();
      logic [IDX_W-1:0] v;
      int unsigned      pick;
      pick = $urandom_range(99);
      v = IDX_W'({$urandom(), $urandom()});
      if (pick < 25) begin
         v = IDX_W'($urandom_range(2000)) - IDX_W'(1000);
      end else if (pick < 55) begin
         // full-width random
      end else if (pick < 70) begin
         v = (IDX_W'(1) << $urandom_range(IDX_W - 1)) + IDX_W'($urandom_range(4)) - IDX_W'(2);
         if ($urandom_range(1) == 1) v = -v;
      end else if (pick < 80) begin
         if ($urandom_range(1) == 1)
            v = 48'h7FFF_FFFF_FFFF - IDX_W'($urandom_range(15));
         else
            v = 48'h8000_0000_0000 + IDX_W'($urandom_range(15));
      end else begin
         v = v >> $urandom_range(IDX_W - 1);
         if ($urandom_range(1) == 1) v = -v;
      end
      return v;
   endfunction

   task automatic offer_index(input logic signed [IDX_W-1:0] idx);
      if (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         req_index <= random_index();
         do @(posedge clock); while ($urandom_range(99) < 16);
      end
      req_valid <= 1'b1;
      req_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_index(idx);
   endtask

   // result side: checks, random stall, and one long hold-off to back up the block
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_pair(rsp_fib_at_index, rsp_fib_at_next);
         if (!held && sb.accepted >= HOLD_AFTER) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 16);
         end
      end
   end

   initial begin
      logic signed [IDX_W-1:0] directed[$];
      directed = {48'sd0, 48'sd1, -48'sd1, 48'sd2, -48'sd2, 48'sd3, -48'sd3,
                  48'sd10, -48'sd10, 48'sd11, -48'sd11, 48'sd90, -48'sd90,
                  48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 48'sh8000_0000_0001,
                  48'sh4000_0000_0000, -48'sh4000_0000_0000,
                  48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA,
                  48'sd1000000006, -48'sd1000000007, 48'sh0000_00FF_FFFF,
                  48'shFFFF_FF00_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) offer_index(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 400 && i < 600);
         offer_index(random_index());
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (sb.expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
